// File: rtl/core/i2c_master_transaction_engine_assert.svh
// Assertion macros for the I2C master transaction engine.
// Included by the top level; needs no other file.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME_CYCLE(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed in same cycle check");
`define ASSERT_NEXT_CYCLE(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed in next cycle check");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst, pre, post)
`define ASSERT_NEXT_CYCLE(label, clk, rst, pre, post)
`endif
`endif

// File: rtl/core/i2cm_pkg.sv
// Shared types and constants of the I2C master transaction engine.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package i2cm_pkg;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_START = 4'd1,
      PH_SENDA = 4'd2,
      PH_SENDD = 4'd3,
      PH_ACKA  = 4'd4,
      PH_ACKD  = 4'd5,
      PH_READ  = 4'd6,
      PH_MACK  = 4'd7,
      PH_STOP  = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NACK_ADR = 2'd1,
      STATUS_NACK_DAT = 2'd2
   } status_type;

   localparam logic [9:0] ACK_LIMIT_RESET = 10'd1000;
   localparam logic [7:0] ADDR_DIR_MASK   = 8'hFE;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] sub_tick;
      logic [3:0] bit_index;
      logic [7:0] shift_reg;
      logic [7:0] bytes_left;
      logic [9:0] ack_timer;
      logic       read_dir;
      status_type err_code;
   } state_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_low;
      logic       busy_res;
      logic       take_tx;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_res;
      status_type status;
   } result_type;

endpackage

// File: rtl/core/i2cm_step.sv
// One bus tick of the I2C master: next state and pin levels from the current state.
// Purely combinational; depends on i2cm_pkg.
`timescale 1ns / 1ps
module i2cm_step (
   input  i2cm_pkg::state_type  cur,
   input  logic                 start_cmd,
   input  logic                 mode,
   input  logic [7:0]           dev_address,
   input  logic [7:0]           byte_count,
   input  logic [7:0]           tx_byte,
   input  logic                 sda_in,
   input  logic [9:0]           ack_limit,
   output i2cm_pkg::state_type  nxt,
   output i2cm_pkg::result_type res
);
   import i2cm_pkg::*;

   logic [3:0] bit_inc;
   logic       bit_wrap;
   logic       sub_zero;
   logic       ack_poll;
   logic       ack_seen;
   logic       ack_miss;
   logic       left_zero;
   logic       addr_read;
   logic [7:0] shift_read;
   logic [7:0] left_after;
   phase_type  phase_nxt;
   state_type  dp;

   assign bit_inc    = cur.bit_index + 4'd1;
   assign bit_wrap   = bit_inc[3];
   assign sub_zero   = (cur.sub_tick == 2'd0);
   assign ack_poll   = (cur.sub_tick == 2'd3);
   assign ack_seen   = ack_poll && !sda_in;
   assign ack_miss   = ack_poll && sda_in && (cur.ack_timer >= ack_limit);
   assign left_zero  = (cur.bytes_left == 8'd0);
   assign addr_read  = (cur.phase == PH_ACKA) && cur.read_dir;
   assign shift_read = {cur.shift_reg[6:0], sda_in};
   assign left_after = left_zero ? 8'd0 : cur.bytes_left - 8'd1;

   always_comb begin
      phase_nxt = cur.phase;
      unique case (cur.phase)
         PH_IDLE: begin
            if (start_cmd) begin
               phase_nxt = PH_START;
            end
         end
         PH_START: phase_nxt = PH_SENDA;
         PH_SENDA, PH_SENDD: begin
            if (!sub_zero && bit_wrap) begin
               phase_nxt = (cur.phase == PH_SENDA) ? PH_ACKA : PH_ACKD;
            end
         end
         PH_ACKA, PH_ACKD: begin
            if (ack_seen) begin
               if (addr_read) begin
                  phase_nxt = left_zero ? PH_STOP : PH_READ;
               end else begin
                  phase_nxt = left_zero ? PH_STOP : PH_SENDD;
               end
            end else if (ack_miss) begin
               phase_nxt = PH_STOP;
            end
         end
         PH_READ: begin
            if (!sub_zero && bit_wrap) begin
               phase_nxt = PH_MACK;
            end
         end
         PH_MACK: begin
            if (cur.sub_tick >= 2'd2) begin
               phase_nxt = left_zero ? PH_STOP : PH_READ;
            end
         end
         PH_STOP: begin
            if (cur.sub_tick >= 2'd2) begin
               phase_nxt = PH_IDLE;
            end
         end
         default: begin
            phase_nxt = start_cmd ? PH_START : PH_IDLE;
         end
      endcase
   end

   always_comb begin
      res          = '0;
      res.scl_out  = 1'b1;
      res.busy_res = 1'b1;
      unique case (cur.phase)
         PH_START: res.sda_low = 1'b1;
         PH_SENDA, PH_SENDD: begin
            res.sda_low = !cur.shift_reg[7];
            res.scl_out = !sub_zero;
         end
         PH_ACKA, PH_ACKD: begin
            res.scl_out = !sub_zero;
            res.take_tx = ack_seen && !addr_read && !left_zero;
         end
         PH_READ: begin
            res.scl_out  = !sub_zero;
            res.rx_valid = !sub_zero && bit_wrap;
            res.rx_byte  = (!sub_zero && bit_wrap) ? shift_read : 8'd0;
         end
         PH_MACK: begin
            res.sda_low = !left_zero;
            res.scl_out = !sub_zero;
         end
         PH_STOP: begin
            if (sub_zero) begin
               res.scl_out = 1'b0;
               res.sda_low = 1'b1;
            end else if (cur.sub_tick == 2'd1) begin
               res.sda_low = 1'b1;
            end else begin
               res.done_res = 1'b1;
               res.busy_res = 1'b0;
            end
         end
         default: res.busy_res = start_cmd;
      endcase
      res.status = nxt.err_code;
   end

   always_comb begin
      dp = cur;
      unique case (cur.phase)
         PH_START: begin
            dp.sub_tick  = 2'd0;
            dp.bit_index = 4'd0;
         end
         PH_SENDA, PH_SENDD: begin
            if (sub_zero) begin
               dp.sub_tick = 2'd1;
            end else begin
               dp.sub_tick  = 2'd0;
               dp.shift_reg = {cur.shift_reg[6:0], 1'b0};
               dp.bit_index = bit_inc;
               if (bit_wrap) begin
                  dp.bit_index = 4'd0;
                  dp.ack_timer = 10'd0;
               end
            end
         end
         PH_ACKA, PH_ACKD: begin
            if (sub_zero) begin
               dp.sub_tick = 2'd1;
            end else if (!ack_poll) begin
               dp.sub_tick = cur.sub_tick + 2'd1;
            end else if (!sda_in) begin
               dp.sub_tick  = 2'd0;
               dp.bit_index = 4'd0;
               if (!addr_read && !left_zero) begin
                  dp.shift_reg  = tx_byte;
                  dp.bytes_left = left_after;
               end
            end else if (ack_miss) begin
               dp.err_code = (cur.phase == PH_ACKA) ? STATUS_NACK_ADR : STATUS_NACK_DAT;
               dp.sub_tick = 2'd0;
            end else begin
               dp.ack_timer = cur.ack_timer + 10'd1;
            end
         end
         PH_READ: begin
            if (sub_zero) begin
               dp.sub_tick = 2'd1;
            end else begin
               dp.sub_tick  = 2'd0;
               dp.shift_reg = shift_read;
               dp.bit_index = bit_inc;
               if (bit_wrap) begin
                  dp.bit_index  = 4'd0;
                  dp.bytes_left = left_after;
               end
            end
         end
         PH_MACK: begin
            dp.sub_tick = (cur.sub_tick < 2'd2) ? cur.sub_tick + 2'd1 : 2'd0;
         end
         PH_STOP: begin
            if (sub_zero) begin
               dp.sub_tick = 2'd1;
            end else if (cur.sub_tick == 2'd1) begin
               dp.sub_tick = 2'd2;
            end else begin
               dp.sub_tick = 2'd0;
            end
         end
         default: begin
            if (start_cmd) begin
               dp.read_dir   = mode;
               dp.bytes_left = byte_count;
               dp.shift_reg  = (dev_address & ADDR_DIR_MASK) | {7'd0, mode};
               dp.err_code   = STATUS_OK;
               dp.bit_index  = 4'd0;
               dp.sub_tick   = 2'd0;
               dp.ack_timer  = 10'd0;
            end
         end
      endcase
   end

   always_comb begin
      nxt       = dp;
      nxt.phase = phase_nxt;
   end

endmodule

// File: rtl/core/i2cm_rsp_buf.sv
// Two-entry result buffer: an output register with a skid entry behind it.
// Depends on i2cm_pkg for the result type.
`timescale 1ns / 1ps
module i2cm_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  i2cm_pkg::result_type push_data,
   input  logic                 pop,
   output i2cm_pkg::result_type head,
   output logic                 head_valid,
   output logic                 full
);
   import i2cm_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   result_type head_ff;
   result_type skid_ff;

   assign head       = head_ff;
   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         head_ff <= (count_ff == 2'd2) ? skid_ff : push_data;
      end else if (push && count_ff == 2'd0) begin
         head_ff <= push_data;
      end
      if (push && !pop && count_ff == 2'd1) begin
         skid_ff <= push_data;
      end
   end

endmodule

// File: rtl/core/i2c_master_transaction_engine.sv
// Top level of the I2C master transaction engine: state registers, ACK limit register
// and result buffer. Depends on i2cm_pkg, i2cm_step, i2cm_rsp_buf and the assertion header.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_valid/req_stall  one bus tick: command, address, count, data, SDA
//   rsp_     out        rsp_valid/rsp_stall  pin levels, status and received data of that tick
//   csr_     in         csr_wr_en            ack_wait_limit, 10 bits
//
// One tick is taken per clock while req_stall is low; its result is registered in the result buffer until taken.
// The tick's work is a single pass through the step logic into a two-entry result buffer.
// Input stalls only while both buffer entries hold results not yet taken.
// Reset returns the engine to idle and loads an ACK limit of 1000.
`timescale 1ns / 1ps
`include "i2c_master_transaction_engine_assert.svh"
module i2c_master_transaction_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_start_cmd,
   input  logic                 req_mode,
   input  logic [7:0]           req_dev_address,
   input  logic [7:0]           req_byte_count,
   input  logic [7:0]           req_tx_byte,
   input  logic                 req_sda_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_scl_out,
   output logic                 rsp_sda_low,
   output logic                 rsp_busy_res,
   output logic                 rsp_take_tx,
   output logic                 rsp_rx_valid,
   output logic [7:0]           rsp_rx_byte,
   output logic                 rsp_done_res,
   output logic [1:0]           rsp_status,
   input  logic                 csr_wr_en,
   input  logic [9:0]           csr_wr_data
);
   import i2cm_pkg::*;

   state_type  st_ff;
   state_type  st_in;
   state_type  st_nxt;
   result_type step_res;
   result_type head;
   logic [9:0] limit_ff;
   logic [9:0] limit_in;
   logic       buf_full;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       take_xfer;
   logic       idle_xfer;

   assign req_stall = buf_full;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   i2cm_step u_step (
      .cur         (st_ff),
      .start_cmd   (req_start_cmd),
      .mode        (req_mode),
      .dev_address (req_dev_address),
      .byte_count  (req_byte_count),
      .tx_byte     (req_tx_byte),
      .sda_in      (req_sda_in),
      .ack_limit   (limit_ff),
      .nxt         (st_nxt),
      .res         (step_res)
   );

   i2cm_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (req_xfer),
      .push_data  (step_res),
      .pop        (rsp_xfer),
      .head       (head),
      .head_valid (rsp_valid),
      .full       (buf_full)
   );

   assign st_in    = req_xfer ? st_nxt : st_ff;
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= '{phase: PH_IDLE, err_code: STATUS_OK, default: '0};
         limit_ff <= ACK_LIMIT_RESET;
      end else begin
         st_ff    <= st_in;
         limit_ff <= limit_in;
      end
   end

   assign rsp_scl_out  = head.scl_out;
   assign rsp_sda_low  = head.sda_low;
   assign rsp_busy_res = head.busy_res;
   assign rsp_take_tx  = head.take_tx;
   assign rsp_rx_valid = head.rx_valid;
   assign rsp_rx_byte  = head.rx_byte;
   assign rsp_done_res = head.done_res;
   assign rsp_status   = head.status;

   assign take_xfer = req_xfer && step_res.take_tx;
   assign idle_xfer = req_xfer && (st_ff.phase == PH_IDLE) && !req_start_cmd;

   `ASSERT_SAME_CYCLE(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   `ASSERT_NEXT_CYCLE(a_take_to_send, clock, reset, take_xfer, st_ff.phase == PH_SENDD)
   `ASSERT_NEXT_CYCLE(a_idle_holds, clock, reset, idle_xfer, st_ff.phase == PH_IDLE)
   `ASSERT_SAME_CYCLE(a_bit_range, clock, reset, 1'b1, st_ff.bit_index < 4'd8)

endmodule
